// ===== sv/fht_pkg.sv =====
package fht_pkg;

	localparam logic [15:0] EMPTY_ID = 16'hFFFF;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RESERVED = 3'd4;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	localparam int HASH_W = 32;

	// one table entry as stored in the slot RAM
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] direction;
		logic [15:0] service_type;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== sv/fht_ram.sv =====
module fht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/flow_id_hash_table.sv =====
// Flow table: maps a connection key (src/dst address, service type and
// optionally direction) to a 16-bit connection id, open addressing with
// linear probing over SLOTS slots held in one RAM.
// Input word on s_axis: a lookup or an insert (tuser[0] = kind). One result
// word per request on m_axis: found_id and status.
// One request at a time; s_axis_tready is high only while the sequencer is
// idle. When SLOTS is a power of two a request goes straight to the probe
// loop; otherwise it first passes reciprocal multiply, back multiply and
// fix-up. The probe loop reads up to SLOTS slots, one RAM read per cycle,
// set by the single read port of the slot RAM. The next word can be taken
// in the same cycle that m_axis_tvalid rises. A rejected insert of id
// 0xFFFF skips the probe loop and goes straight to the result state.
// After reset the block sweeps the RAM writing all ones, one slot per cycle,
// with s_axis_tready low.
// The result sits in an output register; if m_axis_tready is low the block
// holds it and finishes the next request only once that word is taken.
module flow_id_hash_table #(
	parameter int SLOTS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// src_addr[31:0], dst_addr[63:32], service_type[79:64], direction[95:80],
	// new_id[111:96]
	input  logic [111:0] s_axis_tdata,
	// kind[0], use_dir[1]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found_id[15:0], status[18:16], zero[23:19]
	output logic [23:0]  m_axis_tdata
);

	localparam int AW = $clog2(SLOTS);
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
	localparam logic [AW:0] SLOTS_W = (AW + 1)'(SLOTS);
	localparam logic [AW:0] LAST_PROBE = (AW + 1)'(SLOTS - 1);
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(SLOTS));

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_MOD    = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;
	localparam logic [2:0] S_MULQ   = 3'd6;
	localparam logic [2:0] S_FIX    = 3'd7;

	logic [2:0]  state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] idx_q;
	logic [AW:0]   probe_q;
	logic [AW:0]   rem_q;
	logic [31:0]   quo_q;
	logic [fht_pkg::HASH_W-1:0] hash_q;

	logic        kind_q;
	logic        use_dir_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] svc_q;
	logic [15:0] dir_q;
	logic [15:0] nid_q;

	logic [15:0] res_id_q;
	logic [2:0]  res_st_q;
	logic        out_valid_q;
	logic [15:0] out_id_q;
	logic [2:0]  out_st_q;

	fht_pkg::slot_t rd;
	fht_pkg::slot_t wr;
	logic [fht_pkg::SLOT_W-1:0] rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;

	logic [fht_pkg::HASH_W-1:0] in_hash;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	logic [31:0]   hash_diff;
	logic [AW:0]   rem_sub;
	logic [AW-1:0] idx_next;
	logic          key_match;
	logic          slot_empty;
	logic          accept;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	assign in_hash = s_axis_tdata[31:0] | s_axis_tdata[63:32] |
		{16'd0, s_axis_tdata[79:64]} |
		(s_axis_tuser[1] ? {16'd0, s_axis_tdata[95:80]} : 32'd0);

	// one multiplier: hash * reciprocal, then quotient * SLOTS; the quotient
	// estimate is low by at most one, so one subtract finishes the remainder
	assign mul_a = (state_q == S_MOD) ? hash_q : quo_q;
	assign mul_b = (state_q == S_MOD) ? RECIP : 32'(SLOTS);
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
	assign hash_diff = hash_q - mul_p[31:0];
	assign rem_sub = rem_q - SLOTS_W;

	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	assign rd = fht_pkg::slot_t'(rdata);
	assign slot_empty = (rd.id == fht_pkg::EMPTY_ID);
	assign key_match = (rd.src_addr == src_q) && (rd.dst_addr == dst_q) &&
		(rd.service_type == svc_q) && (!use_dir_q || rd.direction == dir_q);

	always_comb begin
		wr.src_addr = src_q;
		wr.dst_addr = dst_q;
		wr.service_type = svc_q;
		wr.direction = use_dir_q ? dir_q : rd.direction;
		wr.id = nid_q;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_re = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				wr = '1;
			end
			S_READ: begin
				ram_re = 1'b1;
			end
			S_CHECK: begin
				if (slot_empty) begin
					ram_we = (kind_q == fht_pkg::KIND_INSERT);
				end else if (!(kind_q == fht_pkg::KIND_LOOKUP && key_match)) begin
					ram_re = 1'b1;
					ram_raddr = idx_next;
				end
			end
			default: begin
			end
		endcase
	end

	fht_ram #(
		.WIDTH(fht_pkg::SLOT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[0] == fht_pkg::KIND_INSERT &&
							s_axis_tdata[111:96] == fht_pkg::EMPTY_ID) begin
							state_q <= S_RESULT;
						end else if (POW2) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					state_q <= S_MULQ;
				end
				S_MULQ: begin
					state_q <= S_FIX;
				end
				S_FIX: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (slot_empty || (kind_q == fht_pkg::KIND_LOOKUP && key_match) ||
						probe_q == LAST_PROBE) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= s_axis_tuser[0];
				use_dir_q <= s_axis_tuser[1];
				src_q <= s_axis_tdata[31:0];
				dst_q <= s_axis_tdata[63:32];
				svc_q <= s_axis_tdata[79:64];
				dir_q <= s_axis_tdata[95:80];
				nid_q <= s_axis_tdata[111:96];
				hash_q <= in_hash;
				idx_q <= in_hash[AW-1:0];
				probe_q <= '0;
				res_id_q <= fht_pkg::EMPTY_ID;
				res_st_q <= fht_pkg::ST_RESERVED;
			end
			S_MOD: begin
				quo_q <= mul_p[63:32];
			end
			S_MULQ: begin
				rem_q <= hash_diff[AW:0];
			end
			S_FIX: begin
				idx_q <= (rem_q >= SLOTS_W) ? rem_sub[AW-1:0] : rem_q[AW-1:0];
			end
			S_CHECK: begin
				probe_q <= probe_q + 1'b1;
				idx_q <= idx_next;
				if (slot_empty) begin
					res_st_q <= (kind_q == fht_pkg::KIND_INSERT) ?
						fht_pkg::ST_INSERTED : fht_pkg::ST_MISS;
				end else if (kind_q == fht_pkg::KIND_LOOKUP && key_match) begin
					res_id_q <= rd.id;
					res_st_q <= fht_pkg::ST_HIT;
				end else begin
					// slot taken with no hit; this status stands if the full sweep ends here
					res_st_q <= (kind_q == fht_pkg::KIND_INSERT) ?
						fht_pkg::ST_FULL : fht_pkg::ST_MISS;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_id_q <= res_id_q;
					out_st_q <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, out_st_q, out_id_q};

endmodule

// ===== tb/sv/flow_id_hash_table_checker.sv =====
module flow_id_hash_table_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic         req_ready,
	// src_addr[31:0], dst_addr[63:32], service_type[79:64], direction[95:80],
	// new_id[111:96]
	input  logic [111:0] req_data,
	// kind[0], use_dir[1]
	input  logic [1:0]   req_user,
	input  logic         res_valid,
	input  logic         res_ready,
	// found_id[15:0], status[18:16], zero[23:19]
	input  logic [23:0]  res_data,
	output int           fail_cnt,
	output int           pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 256;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] found_id;
	} flow_res_t;

	fht_pkg::slot_t flow_tbl [SLOTS];
	flow_res_t      res_q [$];

	// walks the probe path and updates the table copy on a successful insert
	function automatic flow_res_t resolve_req(input logic [111:0] d, input logic [1:0] u);
		logic        kind;
		logic        use_dir;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] svc;
		logic [15:0] dir;
		logic [15:0] nid;
		logic [31:0] home;
		int          idx;
		flow_res_t   r;
		kind    = u[0];
		use_dir = u[1];
		src     = d[31:0];
		dst     = d[63:32];
		svc     = d[79:64];
		dir     = d[95:80];
		nid     = d[111:96];
		home = src | dst | {16'h0, svc} | (use_dir ? {16'h0, dir} : 32'h0);
		idx  = home % SLOTS;
		r.found_id = fht_pkg::EMPTY_ID;
		if (kind == fht_pkg::KIND_LOOKUP) begin
			r.status = fht_pkg::ST_MISS;
			for (int n = 0; n < SLOTS; n++) begin
				if (flow_tbl[idx].id == fht_pkg::EMPTY_ID)
					break;
				if (flow_tbl[idx].src_addr == src && flow_tbl[idx].dst_addr == dst &&
				    flow_tbl[idx].service_type == svc &&
				    (!use_dir || flow_tbl[idx].direction == dir)) begin
					r.found_id = flow_tbl[idx].id;
					r.status   = fht_pkg::ST_HIT;
					break;
				end
				idx = (idx + 1) % SLOTS;
			end
		end else if (nid == fht_pkg::EMPTY_ID) begin
			r.status = fht_pkg::ST_RESERVED;
		end else begin
			r.status = fht_pkg::ST_FULL;
			for (int n = 0; n < SLOTS; n++) begin
				if (flow_tbl[idx].id == fht_pkg::EMPTY_ID) begin
					flow_tbl[idx].src_addr     = src;
					flow_tbl[idx].dst_addr     = dst;
					flow_tbl[idx].service_type = svc;
					// direction stays as it was unless it is part of the key
					if (use_dir)
						flow_tbl[idx].direction = dir;
					flow_tbl[idx].id = nid;
					r.status = fht_pkg::ST_INSERTED;
					break;
				end
				idx = (idx + 1) % SLOTS;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		flow_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				flow_tbl[i] = '1;
			res_q.delete();
			fail_cnt <= 0;
			pending  <= 0;
		end else begin
			if (req_valid && req_ready)
				res_q.push_back(resolve_req(req_data, req_user));
			if (res_valid && res_ready) begin
				if (res_q.size() == 0) begin
					$display("%0t: unexpected result word, got found_id %h status %0d",
					         $time, res_data[15:0], res_data[18:16]);
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = res_q.pop_front();
					if (res_data[15:0] != want.found_id || res_data[18:16] != want.status) begin
						$display("%0t: expected found_id %h status %0d, got found_id %h status %0d",
						         $time, want.found_id, want.status,
						         res_data[15:0], res_data[18:16]);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
			pending <= res_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_flow_id_hash_table.sv =====
module tb_flow_id_hash_table;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_ITEMS  = 395;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic        kind;
		logic        use_dir;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] service_type;
		logic [15:0] direction;
		logic [15:0] new_id;
	} flow_req_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [23:0]  m_axis_tdata;

	int fail_cnt;
	int pending;
	int gap_pct;
	int stall_pct;
	int cycle_cnt = 0;

	flow_req_t seen_keys [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	flow_id_hash_table u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	flow_id_hash_table_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_data  (s_axis_tdata),
		.req_user  (s_axis_tuser),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (m_axis_tdata),
		.fail_cnt  (fail_cnt),
		.pending   (pending)
	);

	always @(negedge clk) begin
		m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("flow_id_hash_table: mismatch");
			$finish;
		end
	end

	function automatic flow_req_t flow_req(input logic kind, input logic use_dir,
	                                       input logic [31:0] src, input logic [31:0] dst,
	                                       input logic [15:0] svc, input logic [15:0] dir,
	                                       input logic [15:0] nid);
		flow_req_t r;
		r = '{kind, use_dir, src, dst, svc, dir, nid};
		return r;
	endfunction

	// mostly keys with one random low byte so home slots spread over the table,
	// lookups reuse inserted keys to get hits
	function automatic flow_req_t pick_flow_req(input int ins_pct);
		flow_req_t   r;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		int          k;
		w0 = $urandom();
		w1 = $urandom();
		w2 = $urandom();
		w3 = $urandom();
		r.kind    = ($urandom_range(99) < ins_pct) ? fht_pkg::KIND_INSERT :
		                                             fht_pkg::KIND_LOOKUP;
		r.use_dir = 1'($urandom_range(1));
		r.new_id  = w3[15:0];
		if ($urandom_range(99) < 30) begin
			r.src_addr     = w0;
			r.dst_addr     = w1;
			r.service_type = w2[15:0];
			r.direction    = w2[31:16];
		end else begin
			r.src_addr     = w0;
			r.dst_addr     = {w1[31:8], 8'h00};
			r.service_type = {w2[15:8], 8'h00};
			r.direction    = {w2[31:24], 8'h00};
		end
		if (r.kind == fht_pkg::KIND_INSERT) begin
			if ($urandom_range(99) < 3)
				r.new_id = fht_pkg::EMPTY_ID;
			else if (r.new_id == fht_pkg::EMPTY_ID)
				r.new_id = 16'h0000;
			if (r.new_id != fht_pkg::EMPTY_ID)
				seen_keys.push_back(r);
		end else if (seen_keys.size() != 0 && $urandom_range(99) < 60) begin
			k = $urandom_range(seen_keys.size() - 1);
			r = seen_keys[k];
			r.kind   = fht_pkg::KIND_LOOKUP;
			r.new_id = w3[15:0];
			if ($urandom_range(99) < 20)
				r.use_dir = ~r.use_dir;
			if ($urandom_range(99) < 10)
				r.direction = w3[31:16];
		end
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_req(input flow_req_t r);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.new_id, r.direction, r.service_type, r.dst_addr, r.src_addr};
		s_axis_tuser  <= {r.use_dir, r.kind};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	initial begin
		int ins_pct;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		gap_pct       = 0;
		stall_pct     = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, reserved id
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b1, '1, '1, '1, '1, '1));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '0, '0, '0, '0, '0));
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b0, 32'h1, 32'h2, 16'h3, 16'h0,
		                  fht_pkg::EMPTY_ID));
		// duplicate key: second copy lands behind the first, lookup sees the first
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b0, '0, '0, '0, '0, 16'h0000));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '0, '0, '0, '0, '0));
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b0, '0, '0, '0, '0, 16'h0001));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '0, '0, '0, '1, '1));
		// top slot taken, next key homed there wraps past slots 0 and 1
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b1, '1, '1, '1, '1, 16'hFFFE));
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b0, '0, '0, 16'h00FF, 16'h0, 16'h1234));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '0, '0, 16'h00FF, 16'h0, '0));
		// direction never written is still all ones
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b1, '0, '0, 16'h00FF, 16'hFFFF, '0));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '1, '1, '1, 16'h0, '0));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b1, '1, '1, '1, 16'h00FF, '0));
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b1, '0, '0, 16'h0034, 16'h1200, 16'h0001));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '0, '0, 16'h0034, 16'h5555, '0));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b1, '0, '0, 16'h0034, 16'h1201, '0));
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b0, '1, '0, '0, '0, 16'h8000));
		send_req(flow_req(fht_pkg::KIND_LOOKUP, 1'b0, '1, '0, '0, '0, fht_pkg::EMPTY_ID));
		send_req(flow_req(fht_pkg::KIND_INSERT, 1'b1, 32'hA5A5A5A5, 32'h5A5A5A5A, 16'hA5A5,
		                  16'h5A5A, 16'hFFFE));

		// light load first; the third phase fills the table, the last runs it full
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					gap_pct = 0;  stall_pct = 0;  ins_pct = 15;
				end
				1: begin
					gap_pct = 80; stall_pct = 0;  ins_pct = 15;
				end
				2: begin
					gap_pct = 0;  stall_pct = 80; ins_pct = 40;
				end
				default: begin
					gap_pct = 33; stall_pct = 33; ins_pct = 30;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_req(pick_flow_req(ins_pct));
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("flow_id_hash_table: match");
		else
			$display("flow_id_hash_table: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
sv/fht_pkg.sv
sv/fht_ram.sv
sv/flow_id_hash_table.sv
tb/sv/flow_id_hash_table_checker.sv
tb/sv/tb_flow_id_hash_table.sv
